/* design/lsfr_pkg.sv */
// ----------------------------------------------------------------------------
// lsfr_pkg
// Shared types, constants and checksum helpers for the LIN slave receiver.
// ----------------------------------------------------------------------------
package lsfr_pkg;

    localparam int DATA_BYTES = 8;                      // data bytes per frame
    localparam int DATA_W     = 8 * DATA_BYTES;         // packed data store width
    localparam int FRAME_W    = 64;                     // frame_data field width
    localparam int CNT_W      = $clog2(DATA_BYTES + 1); // byte counter / index
    localparam int QDEPTH     = 2;                      // command queue depth
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [7:0] SYNC_BYTE       = 8'h55;
    localparam logic [7:0] PID_DIAG_MASTER = 8'h3C;
    localparam logic [7:0] PID_DIAG_SLAVE  = 8'h7D;
    localparam logic [7:0] CSUM_GOOD       = 8'hFF;

    localparam logic [5:0]  EXEC_ID_RST  = 6'h31;
    localparam logic [5:0]  RESP_ID_RST  = 6'h32;
    localparam logic [63:0] RESP_DAT_RST = 64'h0;

    localparam int NREGS = 3;
    typedef enum logic [1:0] {
        REG_EXEC_ID  = 2'd0,
        REG_RESP_ID  = 2'd1,
        REG_RESP_DAT = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_FRAME  = 2'd1,
        KIND_TX     = 2'd2
    } out_kind_t;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_SYNC   = 2'd1,
        ST_PARITY = 2'd2,
        ST_CKSUM  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_STATUS   = 2'd0,
        CMD_FRAME    = 2'd1,
        CMD_RESPONSE = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        status_t            status;
        logic [5:0]         id;
        logic [7:0]         pid;
        logic [FRAME_W-1:0] data;
    } cmd_t;

    // Add one byte with end-around carry.
    function automatic logic [7:0] csum_add(input logic [7:0] s, input logic [7:0] b);
        logic [8:0] t;
        t = {1'b0, s} + {1'b0, b};
        if (t > 9'h0FF) begin
            t = t - 9'h0FF;
        end
        return t[7:0];
    endfunction

    // Enhanced checksum starts from the PID; diagnostic PIDs use classic.
    function automatic logic [7:0] csum_seed(input logic [7:0] pid);
        logic [7:0] s;
        s = pid;
        if (pid == PID_DIAG_MASTER || pid == PID_DIAG_SLAVE) begin
            s = 8'h00;
        end
        return s;
    endfunction

endpackage

/* design/lsfr_front.sv */
// ----------------------------------------------------------------------------
// lsfr_front
// Receive phase machine: sync, PID, data and checksum checks; issues commands.
// ----------------------------------------------------------------------------
module lsfr_front
    import lsfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic       func,
    input  logic [7:0] rx_byte,
    input  logic       framing_error,
    input  logic [5:0] exec_frame_id,
    input  logic [5:0] response_frame_id,
    output logic       cmd_push,
    output cmd_t       cmd
);

    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_SYNC = 3'd1,
        PH_PID  = 3'd2,
        PH_DATA = 3'd3,
        PH_CSUM = 3'd4
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [5:0]        id_reg, id_next;
    logic [7:0]        sum_reg, sum_next;
    logic [DATA_W-1:0] store_reg, store_next;

    function automatic logic [7:0] pid_of(input logic [5:0] id);
        logic p0, p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    logic [5:0] rx_id;
    logic [8:0] csum_total;
    assign rx_id      = rx_byte[5:0];
    assign csum_total = {1'b0, sum_reg} + {1'b0, rx_byte};

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        id_next    = id_reg;
        sum_next   = sum_reg;
        store_next = store_reg;
        cmd_push   = 1'b0;
        cmd        = '{kind: CMD_STATUS, status: ST_NONE, id: 6'd0, pid: 8'd0,
                       data: '0};
        if (accept) begin
            if (!func) begin
                // break: restart the frame in any phase
                phase_next = PH_SYNC;
                cnt_next   = '0;
            end else if (!framing_error) begin
                case (phase_reg)
                    PH_SYNC: begin
                        if (rx_byte != SYNC_BYTE) begin
                            phase_next = PH_WAIT;
                            cmd_push   = 1'b1;
                            cmd.status = ST_SYNC;
                        end else begin
                            phase_next = PH_PID;
                        end
                    end
                    PH_PID: begin
                        phase_next = PH_WAIT;
                        id_next    = rx_id;
                        if (pid_of(rx_id) != rx_byte) begin
                            cmd_push   = 1'b1;
                            cmd.status = ST_PARITY;
                            cmd.id     = rx_id;
                        end else if (rx_id == exec_frame_id) begin
                            phase_next = PH_DATA;
                            cnt_next   = '0;
                            sum_next   = csum_seed(rx_byte);
                        end else if (rx_id == response_frame_id) begin
                            cmd_push = 1'b1;
                            cmd.kind = CMD_RESPONSE;
                            cmd.id   = rx_id;
                            cmd.pid  = rx_byte;
                        end
                    end
                    PH_DATA: begin
                        for (int i = 0; i < DATA_BYTES; i++) begin
                            if (cnt_reg == CNT_W'(i)) begin
                                store_next[8*i +: 8] = rx_byte;
                            end
                        end
                        sum_next = csum_add(sum_reg, rx_byte);
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (cnt_reg == CNT_W'(DATA_BYTES - 1)) begin
                            phase_next = PH_CSUM;
                        end
                    end
                    PH_CSUM: begin
                        phase_next = PH_WAIT;
                        cmd_push   = 1'b1;
                        cmd.id     = id_reg;
                        if (csum_total == {1'b0, CSUM_GOOD}) begin
                            cmd.kind = CMD_FRAME;
                            cmd.data = FRAME_W'(store_reg);
                        end else begin
                            cmd.status = ST_CKSUM;
                        end
                    end
                    default: begin
                        // waiting for break; a bare sync byte also opens a frame
                        phase_next = PH_WAIT;
                        if (rx_byte == SYNC_BYTE) begin
                            phase_next = PH_PID;
                            cnt_next   = '0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT;
            cnt_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
        id_reg    <= id_next;
        sum_reg   <= sum_next;
        store_reg <= store_next;
    end

endmodule

/* design/lsfr_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// lsfr_cmd_fifo
// Short command queue between the receive front and the result back end.
// ----------------------------------------------------------------------------
module lsfr_cmd_fifo
    import lsfr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output cmd_t head
);

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] n;
        n = p + QPTR_W'(1);
        if (p == QPTR_W'(QDEPTH - 1)) begin
            n = '0;
        end
        return n;
    endfunction

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* design/lsfr_back.sv */
// ----------------------------------------------------------------------------
// lsfr_back
// Result generator: one result per cycle into the output register while
// m_ready allows; expands a response into data bytes and inverted checksum.
// ----------------------------------------------------------------------------
module lsfr_back
    import lsfr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    input  cmd_t               cmd,
    output logic               cmd_pop,
    input  logic [63:0]        response_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_out_kind,
    output logic [1:0]         m_status,
    output logic [5:0]         m_frame_id,
    output logic [FRAME_W-1:0] m_frame_data,
    output logic [7:0]         m_tx_byte,
    output logic               m_last
);

    typedef enum logic {
        B_IDLE  = 1'b0,
        B_BURST = 1'b1
    } bstate_t;

    bstate_t            state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [7:0]         sum_reg, sum_next;
    logic [5:0]         bid_reg, bid_next;
    logic               valid_reg, valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic [1:0]         status_reg, status_next;
    logic [5:0]         fid_reg, fid_next;
    logic [FRAME_W-1:0] fdata_reg, fdata_next;
    logic [7:0]         tx_reg, tx_next;
    logic               last_reg, last_next;

    logic       load;
    logic [7:0] resp_byte;

    assign load = !valid_reg || m_ready;

    always_comb begin
        resp_byte = 8'h00;
        for (int i = 0; i < DATA_BYTES; i++) begin
            if (idx_reg == CNT_W'(i)) begin
                resp_byte = response_data[8*i +: 8];
            end
        end
    end

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        bid_next    = bid_reg;
        valid_next  = valid_reg;
        kind_next   = kind_reg;
        status_next = status_reg;
        fid_next    = fid_reg;
        fdata_next  = fdata_reg;
        tx_next     = tx_reg;
        last_next   = last_reg;
        cmd_pop     = 1'b0;
        if (load) begin
            valid_next  = 1'b0;
            status_next = ST_NONE;
            fdata_next  = '0;
            tx_next     = 8'h00;
            last_next   = 1'b0;
            case (state_reg)
                B_BURST: begin
                    valid_next = 1'b1;
                    kind_next  = KIND_TX;
                    fid_next   = bid_reg;
                    if (idx_reg == CNT_W'(DATA_BYTES)) begin
                        tx_next    = ~sum_reg;
                        last_next  = 1'b1;
                        state_next = B_IDLE;
                    end else begin
                        tx_next  = resp_byte;
                        sum_next = csum_add(sum_reg, resp_byte);
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
                default: begin
                    if (cmd_valid) begin
                        cmd_pop    = 1'b1;
                        valid_next = 1'b1;
                        fid_next   = cmd.id;
                        case (cmd.kind)
                            CMD_FRAME: begin
                                kind_next  = KIND_FRAME;
                                fdata_next = cmd.data;
                                last_next  = 1'b1;
                            end
                            CMD_RESPONSE: begin
                                // send byte zero now, the rest from the burst
                                kind_next  = KIND_TX;
                                tx_next    = response_data[7:0];
                                sum_next   = csum_add(csum_seed(cmd.pid), response_data[7:0]);
                                idx_next   = CNT_W'(1);
                                bid_next   = cmd.id;
                                state_next = B_BURST;
                            end
                            default: begin
                                kind_next   = KIND_STATUS;
                                status_next = cmd.status;
                                last_next   = 1'b1;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        idx_reg    <= idx_next;
        sum_reg    <= sum_next;
        bid_reg    <= bid_next;
        kind_reg   <= kind_next;
        status_reg <= status_next;
        fid_reg    <= fid_next;
        fdata_reg  <= fdata_next;
        tx_reg     <= tx_next;
        last_reg   <= last_next;
    end

    assign m_valid      = valid_reg;
    assign m_out_kind   = kind_reg;
    assign m_status     = status_reg;
    assign m_frame_id   = fid_reg;
    assign m_frame_data = fdata_reg;
    assign m_tx_byte    = tx_reg;
    assign m_last       = last_reg;

endmodule

/* design/lin_slave_frame_receiver.sv */
// ----------------------------------------------------------------------------
// lin_slave_frame_receiver
// Receive side of a LIN 2.x slave with enhanced checksum handling.
// ----------------------------------------------------------------------------
// Feed break events (s_func = 0) and UART bytes (s_func = 1) one item per
// cycle while s_ready is high; bytes flagged with a framing error are
// dropped. A break, or a bare 0x55 while waiting for a break, opens a frame.
// The block checks the sync byte and PID parity, then collects and checksums
// the data of the exec frame ID, or answers the response frame ID with eight
// configured bytes and their inverted checksum. Every input item is taken at
// once while the two-entry command queue has room; the back end writes one
// result per cycle into the output register unless m_ready holds it;
// back-to-back response requests or a low m_ready can fill the queue and
// drop s_ready. All other items cause at most one result. Each result carries
// m_last on the final result of the input item that caused it. Write the
// configuration registers (index 0 exec ID, 1 response ID, 2 response data)
// only while no results are pending; cfg_ready is always high.
// ----------------------------------------------------------------------------
module lin_slave_frame_receiver
    import lsfr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // input items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic [7:0]         s_rx_byte,
    input  logic               s_framing_error,
    // result items
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_out_kind,
    output logic [1:0]         m_status,
    output logic [5:0]         m_frame_id,
    output logic [FRAME_W-1:0] m_frame_data,
    output logic [7:0]         m_tx_byte,
    output logic               m_last,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    logic [5:0]  exec_id_reg;
    logic [5:0]  resp_id_reg;
    logic [63:0] resp_data_reg;

    logic accept;
    logic cmd_push, cmd_pop, q_full, q_not_empty;
    cmd_t push_cmd, head_cmd;

    // Configuration: always ready, indexes beyond the list are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exec_id_reg   <= EXEC_ID_RST;
            resp_id_reg   <= RESP_ID_RST;
            resp_data_reg <= RESP_DAT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_EXEC_ID:  exec_id_reg   <= cfg_data[5:0];
                REG_RESP_ID:  resp_id_reg   <= cfg_data[5:0];
                REG_RESP_DAT: resp_data_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hold input back only when the command queue is full.
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    lsfr_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .accept            (accept),
        .func              (s_func),
        .rx_byte           (s_rx_byte),
        .framing_error     (s_framing_error),
        .exec_frame_id     (exec_id_reg),
        .response_frame_id (resp_id_reg),
        .cmd_push          (cmd_push),
        .cmd               (push_cmd)
    );

    lsfr_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_cmd  (push_cmd),
        .pop       (cmd_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head_cmd)
    );

    lsfr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (q_not_empty),
        .cmd           (head_cmd),
        .cmd_pop       (cmd_pop),
        .response_data (resp_data_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_kind    (m_out_kind),
        .m_status      (m_status),
        .m_frame_id    (m_frame_id),
        .m_frame_data  (m_frame_data),
        .m_tx_byte     (m_tx_byte),
        .m_last        (m_last)
    );

    // A command is only issued for an accepted input item.
    a_push_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_push |-> accept)
        else $error("command issued without an accepted item");

    // The back end never pops an empty queue.
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> q_not_empty)
        else $error("command queue popped while empty");

    // Status and frame results always close their input item.
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_out_kind == KIND_STATUS || m_out_kind == KIND_FRAME)) |-> m_last)
        else $error("single result without last");

    // After a pop the output register holds a valid result.
    a_pop_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |=> m_valid)
        else $error("popped command produced no result");

endmodule
